[hw/rtl/ptd_pkg.sv]
// shared types, constants and microcode rom of the periodic task dispatcher
package ptd_pkg;

  localparam int unsigned SlotW  = 6;
  localparam int unsigned FreqW  = 20;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned StepW  = 4;
  localparam int unsigned IterW  = 5;

  localparam logic [FreqW-1:0] UsPerSecond = FreqW'(1000000);
  localparam logic [IterW-1:0] DivIters    = IterW'(FreqW);

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StZeroFreq = 2'd2;

  localparam logic KindTick = 1'b0;
  localparam logic KindAdd  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] now_us;
    logic [FreqW-1:0] frequency_hz;
  } in_word_t;

  typedef struct packed {
    logic             fired;
    logic [SlotW-1:0] slot;
    logic [1:0]       status;
  } out_word_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_IS_ADD,
    C_TICK_SKIP,
    C_DUE,
    C_MORE,
    C_ZERO_FREQ,
    C_FULL,
    C_DIV_MORE
  } cond_e;

  typedef enum logic [2:0] {
    E_NONE,
    E_TICK_NONE,
    E_FIRE,
    E_ADD,
    E_ZERO_FREQ,
    E_FULL
  } emit_e;

  typedef struct packed {
    logic  load;
    logic  clr_idx;
    logic  adv;
    logic  wr_lr;
    logic  div_init;
    logic  div_step;
    logic  wr_per;
    emit_e emit;
  } act_t;

  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    act_t             act;
  } ctrl_t;

  // datapath flags tested by the jump conditions
  typedef struct packed {
    logic start;
    logic is_add;
    logic tick_skip;
    logic due;
    logic more;
    logic zero_freq;
    logic full;
    logic div_more;
  } flags_t;

  localparam logic [StepW-1:0] SIdle    = 4'd0;
  localparam logic [StepW-1:0] SDisp    = 4'd1;
  localparam logic [StepW-1:0] STick    = 4'd2;
  localparam logic [StepW-1:0] SRd      = 4'd3;
  localparam logic [StepW-1:0] SEv      = 4'd4;
  localparam logic [StepW-1:0] SNext    = 4'd5;
  localparam logic [StepW-1:0] SNone    = 4'd6;
  localparam logic [StepW-1:0] SFire    = 4'd7;
  localparam logic [StepW-1:0] SAdd     = 4'd8;
  localparam logic [StepW-1:0] SInit    = 4'd9;
  localparam logic [StepW-1:0] SDiv     = 4'd10;
  localparam logic [StepW-1:0] SAddDone = 4'd11;
  localparam logic [StepW-1:0] SZf      = 4'd12;
  localparam logic [StepW-1:0] SFull    = 4'd13;

  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t c;
    c        = '0;
    c.cond   = C_NEVER;
    c.target = SIdle;
    c.act.emit = E_NONE;
    unique case (step)
      SIdle: begin
        c.act.load = 1'b1;
        c.cond     = C_NO_START;
        c.target   = SIdle;
      end
      SDisp: begin
        c.cond   = C_IS_ADD;
        c.target = SAdd;
      end
      STick: begin
        c.act.clr_idx = 1'b1;
        c.cond        = C_TICK_SKIP;
        c.target      = SNone;
      end
      // table read in flight
      SRd: begin
        c.cond = C_NEVER;
      end
      SEv: begin
        c.cond   = C_DUE;
        c.target = SFire;
      end
      SNext: begin
        c.act.adv = 1'b1;
        c.cond    = C_MORE;
        c.target  = SRd;
      end
      SNone: begin
        c.act.emit = E_TICK_NONE;
        c.cond     = C_ALWAYS;
        c.target   = SIdle;
      end
      SFire: begin
        c.act.wr_lr = 1'b1;
        c.act.emit  = E_FIRE;
        c.cond      = C_ALWAYS;
        c.target    = SIdle;
      end
      SAdd: begin
        c.cond   = C_ZERO_FREQ;
        c.target = SZf;
      end
      SInit: begin
        c.act.div_init = 1'b1;
        c.cond         = C_FULL;
        c.target       = SFull;
      end
      SDiv: begin
        c.act.div_step = 1'b1;
        c.cond         = C_DIV_MORE;
        c.target       = SDiv;
      end
      SAddDone: begin
        c.act.wr_per = 1'b1;
        c.act.emit   = E_ADD;
        c.cond       = C_ALWAYS;
        c.target     = SIdle;
      end
      SZf: begin
        c.act.emit = E_ZERO_FREQ;
        c.cond     = C_ALWAYS;
        c.target   = SIdle;
      end
      SFull: begin
        c.act.emit = E_FULL;
        c.cond     = C_ALWAYS;
        c.target   = SIdle;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = SIdle;
      end
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/ptd_ram.sv]
// generic single-port-write ram with registered read
module ptd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ptd_div.sv]
// restoring divider: one quotient bit per cycle of 1000000 / divisor
module ptd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      init_i,
  input  logic                      step_i,
  input  logic [ptd_pkg::FreqW-1:0] divisor_i,
  output logic [ptd_pkg::FreqW-1:0] quotient_o,
  output logic                      more_o
);

  logic [ptd_pkg::FreqW-1:0] rem_q, rem_d;
  logic [ptd_pkg::FreqW-1:0] quo_q, quo_d;
  logic [ptd_pkg::IterW-1:0] cnt_q, cnt_d;
  logic [ptd_pkg::FreqW:0]   trial;
  logic                      fits;

  assign trial = {rem_q, quo_q[ptd_pkg::FreqW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (init_i) begin
      rem_d = '0;
      quo_d = ptd_pkg::UsPerSecond;
      cnt_d = ptd_pkg::DivIters;
    end else if (step_i) begin
      rem_d = fits ? ptd_pkg::FreqW'(trial - {1'b0, divisor_i})
                   : ptd_pkg::FreqW'(trial);
      quo_d = {quo_q[ptd_pkg::FreqW-2:0], fits};
      cnt_d = cnt_q - ptd_pkg::IterW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  // the step that sees a count of one produces the last bit
  assign more_o     = cnt_q != ptd_pkg::IterW'(1);

endmodule

[hw/rtl/ptd_useq.sv]
// microcode sequencer: step counter, rom lookup and conditional jumps
module ptd_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptd_pkg::flags_t flags_i,
  output ptd_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);

  logic [ptd_pkg::StepW-1:0] upc_q, upc_d;
  ptd_pkg::ctrl_t            ctrl;
  logic                      take;

  assign ctrl = ptd_pkg::ucode(upc_q);

  always_comb begin
    case (ctrl.cond)
      ptd_pkg::C_NEVER:     take = 1'b0;
      ptd_pkg::C_ALWAYS:    take = 1'b1;
      ptd_pkg::C_NO_START:  take = !flags_i.start;
      ptd_pkg::C_IS_ADD:    take = flags_i.is_add;
      ptd_pkg::C_TICK_SKIP: take = flags_i.tick_skip;
      ptd_pkg::C_DUE:       take = flags_i.due;
      ptd_pkg::C_MORE:      take = flags_i.more;
      ptd_pkg::C_ZERO_FREQ: take = flags_i.zero_freq;
      ptd_pkg::C_FULL:      take = flags_i.full;
      ptd_pkg::C_DIV_MORE:  take = flags_i.div_more;
      default:              take = 1'b1;
    endcase
    upc_d = take ? ctrl.target : upc_q + ptd_pkg::StepW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ptd_pkg::SIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = upc_q != ptd_pkg::SIdle;

endmodule

[hw/rtl/periodic_task_dispatcher.sv]
// periodic task dispatcher top level: slot tables, scan datapath and result register
//
//   channel   direction  handshake                 payload
//   command   in         start && !busy            in_i (ptd_pkg::in_word_t)
//   result    out        done_o, one cycle strobe  result_o (ptd_pkg::out_word_t)
//   config    in         cfg_we_i                  cfg_wdata_i (pause_enable)
//
// a tick skips the scan when paused or empty, else it makes a read-then-compare walk
// through the slot tables until a slot is due or the filled slots run out
// an add runs through the 20-step restoring divider
// the result strobe rises in the cycle after the last step; busy is low in that cycle
// ready right after reset; the receiver cannot stall the result
module periodic_task_dispatcher #(
  parameter int unsigned MAX_TASKS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ptd_pkg::in_word_t in_i,
  output logic              done_o,
  output ptd_pkg::out_word_t result_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  ptd_pkg::ctrl_t  ctrl;
  ptd_pkg::flags_t flags;

  logic                        pause_q;
  logic                        kind_q;
  logic [ptd_pkg::TimeW-1:0]   now_q;
  logic [ptd_pkg::FreqW-1:0]   freq_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [CntW-1:0]             idx_q, idx_d;
  logic [MAX_TASKS-1:0]        lrv_q, lrv_d;
  logic                        done_q;
  ptd_pkg::out_word_t          out_q, out_d;

  logic [IdxW-1:0]             idx_a;
  logic [IdxW-1:0]             cnt_a;
  logic [ptd_pkg::FreqW-1:0]   per_rdata;
  logic [ptd_pkg::TimeW-1:0]   lr_rdata;
  logic [ptd_pkg::TimeW-1:0]   lr_val;
  logic [ptd_pkg::TimeW-1:0]   elapsed;
  logic [ptd_pkg::FreqW-1:0]   quotient;
  logic                        div_more;
  logic                        accept;

  assign idx_a  = idx_q[IdxW-1:0];
  assign cnt_a  = count_q[IdxW-1:0];
  assign accept = start && !busy;

  ptd_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ptd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (ctrl.act.div_init),
    .step_i     (ctrl.act.div_step),
    .divisor_i  (freq_q),
    .quotient_o (quotient),
    .more_o     (div_more)
  );

  ptd_ram #(
    .Width (ptd_pkg::FreqW),
    .Depth (MAX_TASKS)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.act.wr_per),
    .waddr_i (cnt_a),
    .wdata_i (quotient),
    .raddr_i (idx_a),
    .rdata_o (per_rdata)
  );

  ptd_ram #(
    .Width (ptd_pkg::TimeW),
    .Depth (MAX_TASKS)
  ) u_last_run_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.act.wr_lr),
    .waddr_i (idx_a),
    .wdata_i (now_q),
    .raddr_i (idx_a),
    .rdata_o (lr_rdata)
  );

  // a slot that never fired has a last-run time of zero
  assign lr_val  = lrv_q[idx_a] ? lr_rdata : '0;
  assign elapsed = now_q - lr_val;

  always_comb begin
    flags.start     = start;
    flags.is_add    = kind_q == ptd_pkg::KindAdd;
    flags.tick_skip = pause_q || (count_q == '0);
    flags.due       = elapsed >= ptd_pkg::TimeW'(per_rdata);
    flags.more      = (idx_q + CntW'(1)) != count_q;
    flags.zero_freq = freq_q == '0;
    flags.full      = count_q == CntW'(MAX_TASKS);
    flags.div_more  = div_more;
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    lrv_d   = lrv_q;
    out_d   = out_q;
    if (ctrl.act.clr_idx) begin
      idx_d = '0;
    end else if (ctrl.act.adv) begin
      idx_d = idx_q + CntW'(1);
    end
    if (ctrl.act.wr_lr) begin
      lrv_d[idx_a] = 1'b1;
    end
    case (ctrl.act.emit)
      ptd_pkg::E_TICK_NONE: begin
        out_d = '{fired: 1'b0, slot: '0, status: ptd_pkg::StOk};
      end
      ptd_pkg::E_FIRE: begin
        out_d = '{fired: 1'b1, slot: ptd_pkg::SlotW'(idx_a), status: ptd_pkg::StOk};
      end
      ptd_pkg::E_ADD: begin
        out_d   = '{fired: 1'b0, slot: ptd_pkg::SlotW'(cnt_a), status: ptd_pkg::StOk};
        count_d = count_q + CntW'(1);
      end
      ptd_pkg::E_ZERO_FREQ: begin
        out_d = '{fired: 1'b0, slot: '0, status: ptd_pkg::StZeroFreq};
      end
      ptd_pkg::E_FULL: begin
        out_d = '{fired: 1'b0, slot: '0, status: ptd_pkg::StFull};
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
      lrv_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pause_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      idx_q   <= idx_d;
      lrv_q   <= lrv_d;
      done_q  <= ctrl.act.emit != ptd_pkg::E_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.act.load && accept) begin
      kind_q <= in_i.kind;
      now_q  <= in_i.now_us;
      freq_q <= in_i.frequency_hz;
    end
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TASKS))
    else $error("slot fill count above table size");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not start the sequencer");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.fired |-> result_o.status == ptd_pkg::StOk
      && ptd_pkg::SlotW'(count_q) > result_o.slot)
    else $error("fired slot outside the filled range");

endmodule
